[rtl/pfx_pkg.sv]
// Shared types, constants and the character decoder of the postfix evaluator.
`default_nettype none
package pfx_pkg;

    localparam int DATA_W          = 32;
    localparam int CHAR_W          = 8;
    localparam int STACK_DEPTH_DEF = 128;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;

    typedef enum logic [2:0] {
        OP_SPACE,
        OP_DIGIT,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_OTHER
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV
    } state_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } div_rsp_t;

    function automatic op_t decode_char(input logic [CHAR_W-1:0] ch);
        op_t op;
        if (ch == CH_SPACE)
            op = OP_SPACE;
        else if (ch >= CH_ZERO && ch <= CH_NINE)
            op = OP_DIGIT;
        else if (ch == CH_PLUS)
            op = OP_ADD;
        else if (ch == CH_MINUS)
            op = OP_SUB;
        else if (ch == CH_STAR)
            op = OP_MUL;
        else if (ch == CH_SLASH)
            op = OP_DIV;
        else
            op = OP_OTHER;
        return op;
    endfunction

endpackage
`default_nettype wire

[rtl/pfx_stack_mem.sv]
// Synchronous stack memory: one write port, one read port with registered data.
`default_nettype none
module pfx_stack_mem #(
    parameter int DEPTH = pfx_pkg::STACK_DEPTH_DEF,
    parameter int WIDTH = pfx_pkg::DATA_W
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

[rtl/pfx_divider.sv]
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module pfx_divider (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pfx_pkg::div_req_t req,
    output pfx_pkg::div_rsp_t      rsp
);
    import pfx_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] div_reg, div_next;
    logic              neg_reg, neg_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        logic [DATA_W:0] shifted;
        logic [DATA_W:0] trial;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        shifted   = {rem_reg, quo_reg[DATA_W-1]};
        trial     = shifted - {1'b0, div_reg};
        if (req.start)
        begin
            // Work on magnitudes; the most negative value keeps its bit pattern.
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend[DATA_W-1] ? (DATA_W'(0) - req.dividend) : req.dividend;
            div_next  = req.divisor[DATA_W-1] ? (DATA_W'(0) - req.divisor) : req.divisor;
            neg_next  = req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
        end
        else if (busy_reg)
        begin
            if (!trial[DATA_W])
            begin
                rem_next = trial[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DATA_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? (DATA_W'(0) - quo_reg) : quo_reg;

endmodule
`default_nettype wire

[rtl/postfix_expression_evaluator_unit.sv]
// Top level of the postfix expression evaluator: control, stack cache and result stage.
//
// Usage. Characters of a postfix expression arrive one per request on the slave
// stream (s_tdata holds the ASCII byte, s_tlast marks the final character). A
// space is skipped, a digit is pushed, '+', '-', '*' and '/' pop two words and
// push the result, and any other character pops two words and pushes nothing.
// After the final character the top of the stack is sent on the master stream
// (m_tdata is the 32-bit result, m_tuser flags a division by zero anywhere in
// the expression) and the stack and error flag clear.
//
// Timing. Spaces and digits finish in the idle state; another character
// reads the second stack word from the registered memory and computes in
// the execute state, where a division by a non-zero word hands over to the
// one-bit-per-cycle divider and waits in the divide state. m_tvalid rises
// at the edge that takes a final space or digit.
//
// Reset clears the stack count, error flag, state and output valid; the stack
// memory is not cleared because only entries below the count are ever used.
// The result register holds one result; while it waits for m_tready further
// characters are still taken, and only a final character is held off until the
// result has gone.
`default_nettype none
module postfix_expression_evaluator_unit #(
    parameter int STACK_DEPTH = pfx_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [pfx_pkg::CHAR_W-1:0] s_tdata,   // [7:0] character
    input  wire logic                       s_tlast,   // last_char
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic      [pfx_pkg::DATA_W-1:0] m_tdata,   // [31:0] result_value
    output logic                            m_tuser    // [0] divide_by_zero
);
    import pfx_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // The top of the stack lives in tos_reg; entries below it live in memory,
    // so entry k of the stack sits at address k while k < count - 1.
    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              err_reg, err_next;
    logic [DATA_W-1:0] tos_reg, tos_next;
    op_t               op_reg, op_next;
    logic              last_reg, last_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_value_reg, out_value_next;
    logic              out_err_reg, out_err_next;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    div_req_t          div_req;
    div_rsp_t          div_rsp;

    op_t               op_in;
    logic              in_accept;
    logic              out_free;

    assign op_in     = decode_char(s_tdata);
    assign out_free  = !out_valid_reg || m_tready;
    // A final character needs the result register to be free when it is taken;
    // nothing else can fill it while that character is at work.
    assign s_tready  = (state_reg == ST_IDLE) && (!s_tlast || out_free);
    assign in_accept = s_tvalid && s_tready;

    // Writes happen only for a digit taken in the idle state, and reads only
    // for an operator or unknown character taken there, so the two never meet
    // in one cycle; a read in the cycle after a write sees the written word.
    pfx_stack_mem #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (DATA_W)
    ) u_stack_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    pfx_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tos_reg       <= tos_next;
        op_reg        <= op_next;
        last_reg      <= last_next;
        out_value_reg <= out_value_next;
        out_err_reg   <= out_err_next;
    end

    always_comb
    begin
        logic [DATA_W-1:0] a_val;
        logic [DATA_W-1:0] b_val;
        logic [DATA_W-1:0] res;
        logic [DATA_W-1:0] digit;
        logic              emit;
        logic [DATA_W-1:0] emit_val;
        logic              div_hit;
        logic              push_res;

        state_next     = state_reg;
        count_next     = count_reg;
        err_next       = err_reg;
        tos_next       = tos_reg;
        op_next        = op_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_value_next = out_value_reg;
        out_err_next   = out_err_reg;

        mem_we    = 1'b0;
        mem_waddr = AW'(count_reg - CW'(1));
        mem_wdata = tos_reg;
        mem_re    = 1'b0;
        mem_raddr = (op_in == OP_OTHER) ? AW'(count_reg - CW'(3)) : AW'(count_reg - CW'(2));

        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;

        // Popping an empty stack yields zero.
        b_val    = (count_reg >= CW'(1)) ? tos_reg : '0;
        a_val    = (count_reg >= CW'(2)) ? mem_rdata : '0;
        res      = '0;
        digit    = {{(DATA_W - CHAR_W){1'b0}}, CHAR_W'(s_tdata - CH_ZERO)};
        emit     = 1'b0;
        emit_val = '0;
        div_hit  = 1'b0;
        push_res = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    op_next   = op_in;
                    last_next = s_tlast;
                    unique case (op_in)
                        OP_SPACE:
                        begin
                            emit     = s_tlast;
                            emit_val = (count_reg != '0) ? tos_reg : '0;
                        end
                        OP_DIGIT:
                        begin
                            // A push onto a full stack is dropped.
                            if (count_reg < CW'(STACK_DEPTH))
                            begin
                                mem_we     = (count_reg != '0);
                                tos_next   = digit;
                                count_next = count_reg + CW'(1);
                            end
                            emit     = s_tlast;
                            emit_val = (count_reg < CW'(STACK_DEPTH)) ? digit : tos_reg;
                        end
                        default:
                        begin
                            mem_re     = 1'b1;
                            state_next = ST_EXEC;
                        end
                    endcase
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                unique case (op_reg)
                    OP_ADD:
                    begin
                        res      = a_val + b_val;
                        push_res = 1'b1;
                    end
                    OP_SUB:
                    begin
                        res      = a_val - b_val;
                        push_res = 1'b1;
                    end
                    OP_MUL:
                    begin
                        res      = a_val * b_val;
                        push_res = 1'b1;
                    end
                    OP_DIV:
                    begin
                        if (b_val == '0)
                        begin
                            res      = '0;
                            div_hit  = 1'b1;
                            push_res = 1'b1;
                        end
                        else
                        begin
                            div_req.start    = 1'b1;
                            div_req.dividend = a_val;
                            div_req.divisor  = b_val;
                            state_next       = ST_DIV;
                        end
                    end
                    default:
                    begin
                        // Unknown character: two pops, no push; the word read
                        // from memory becomes the new top.
                        count_next = (count_reg >= CW'(2)) ? count_reg - CW'(2) : '0;
                        tos_next   = mem_rdata;
                        emit       = last_reg;
                        emit_val   = (count_reg >= CW'(3)) ? mem_rdata : '0;
                    end
                endcase
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    res        = div_rsp.quotient;
                    push_res   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Two pops and one push leave the count one lower, or at one.
        if (push_res)
        begin
            tos_next   = res;
            count_next = (count_reg >= CW'(2)) ? count_reg - CW'(1) : CW'(1);
            emit       = last_reg;
            emit_val   = res;
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
            out_value_next = emit_val;
            out_err_next   = err_reg || div_hit;
            count_next     = '0;
            err_next       = 1'b0;
        end
        else if (div_hit)
        begin
            err_next = 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_err_reg;

endmodule
`default_nettype wire

[rtl/pfx_checker.sv]
// Port-level checks of the postfix evaluator and the bind that attaches them.
`default_nettype none
module pfx_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       s_tvalid,
    input wire logic                       s_tready,
    input wire logic [pfx_pkg::CHAR_W-1:0] s_tdata,
    input wire logic                       s_tlast,
    input wire logic                       m_tvalid,
    input wire logic                       m_tready,
    input wire logic [pfx_pkg::DATA_W-1:0] m_tdata,
    input wire logic                       m_tuser
);
    import pfx_pkg::*;

    logic s_acc;
    logic quick_char;

    assign s_acc      = s_tvalid && s_tready;
    assign quick_char = (s_tdata == CH_SPACE) || (s_tdata >= CH_ZERO && s_tdata <= CH_NINE);

    // A stalled result holds still.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A request that is neither a space nor a digit keeps the block busy, with s_tready low, once it is taken.
    a_op_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && !quick_char |=> !s_tready)
        else $error("request taken during operator execution");

    // A final space or digit gives its result in the next cycle.
    a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && s_tlast && quick_char |=> m_tvalid)
        else $error("missing result after final character");

    // A final character is never taken while a stalled result occupies the output.
    a_last_held: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tlast && m_tvalid && !m_tready |-> !s_tready)
        else $error("final character taken while result stalled");

endmodule

bind postfix_expression_evaluator_unit pfx_checker u_pfx_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

[dv/tb_postfix_expression_evaluator_unit.sv]
// Self-checking testbench for the postfix expression evaluator unit.
`timescale 1ns / 100ps

module tb_postfix_expression_evaluator_unit;
    import pfx_pkg::*;

    localparam int          CLK_PERIOD  = 20;
    localparam int          STACK_WORDS = STACK_DEPTH_DEF;
    localparam int          ITEM_TARGET = 1100;
    localparam int          DRAIN_EVERY = 300;
    localparam int          SETTLE_CYC  = 64;
    localparam int unsigned TIMEOUT_NS  = 12_000_000;

    // The four arithmetic operators, for picking one at random.
    localparam logic [CHAR_W-1:0] OPERATORS [4] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};

    // One entry of the stimulus queue. An entry with drain set carries no
    // character: it holds the sender back until every result has come home.
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              is_last;
        logic              drain;
    } char_req_t;

    // One result as the evaluator should deliver it.
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              div_zero;
    } eval_result_t;

    // Stall patterns of the result receiver.
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_SPARSE
    } rx_mode_t;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [CHAR_W-1:0] s_tdata  = '0;
    logic              s_tlast  = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic              m_tuser;

    char_req_t    char_queue[$];
    eval_result_t pending_results[$];
    int           outstanding = 0;
    int           fail_count  = 0;
    int           stim_items  = 0;

    // Predictor state: its own copy of the operand stack and the sticky
    // division-by-zero flag.
    logic [DATA_W-1:0] operand_stack [STACK_WORDS];
    int                stack_fill = 0;
    logic              dz_sticky  = 1'b0;

    // Sender pacing and receiver pattern state.
    int       burst_left = 0;
    int       gap_left   = 0;
    int       rx_cycle   = 0;
    rx_mode_t rx_mode    = RX_OPEN;

    postfix_expression_evaluator_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] character
        .s_tlast  (s_tlast),   // last_char
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [31:0] result_value
        .m_tuser  (m_tuser)    // [0] divide_by_zero
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // A push onto a full stack is silently lost.
    function automatic void push_operand(input logic [DATA_W-1:0] word);
        if (stack_fill < STACK_WORDS)
        begin
            operand_stack[stack_fill] = word;
            stack_fill++;
        end
    endfunction

    // Popping an empty stack yields zero and leaves it empty.
    function automatic logic [DATA_W-1:0] pop_operand();
        if (stack_fill == 0)
            return '0;
        stack_fill--;
        return operand_stack[stack_fill];
    endfunction

    // Signed division rounding toward zero, worked on magnitudes so that the
    // most negative value over minus one wraps back onto itself.
    function automatic logic [DATA_W-1:0] quotient_toward_zero(
        input logic [DATA_W-1:0] num,
        input logic [DATA_W-1:0] den
    );
        logic [DATA_W-1:0] mag_n;
        logic [DATA_W-1:0] mag_d;
        logic [DATA_W-1:0] quo;
        mag_n = num[DATA_W-1] ? -num : num;
        mag_d = den[DATA_W-1] ? -den : den;
        quo   = mag_n / mag_d;
        return (num[DATA_W-1] ^ den[DATA_W-1]) ? -quo : quo;
    endfunction

    // Applies one accepted character to the predicted stack and, on the final
    // character, queues the result that the block must send.
    task automatic evaluate_char(input logic [CHAR_W-1:0] ch, input logic is_last);
        logic [DATA_W-1:0] lhs;
        logic [DATA_W-1:0] rhs;
        eval_result_t      res;
        if (ch == CH_SPACE)
        begin
            // Spaces leave the stack alone.
        end
        else if (ch >= CH_ZERO && ch <= CH_NINE)
        begin
            push_operand({24'd0, ch - CH_ZERO});
        end
        else
        begin
            // The right-hand operand sits on top, so it comes off first.
            rhs = pop_operand();
            lhs = pop_operand();
            case (ch)
                CH_PLUS:  push_operand(lhs + rhs);
                CH_MINUS: push_operand(lhs - rhs);
                CH_STAR:  push_operand(lhs * rhs);
                CH_SLASH:
                    if (rhs == '0)
                    begin
                        dz_sticky = 1'b1;
                        push_operand('0);
                    end
                    else
                    begin
                        push_operand(quotient_toward_zero(lhs, rhs));
                    end
                default: ;   // An unknown character only discards two words.
            endcase
        end
        if (is_last)
        begin
            res.value    = pop_operand();
            res.div_zero = dz_sticky;
            pending_results.push_back(res);
            stack_fill = 0;
            dz_sticky  = 1'b0;
        end
    endtask

    task automatic report_mismatch(
        input string             what,
        input logic [DATA_W-1:0] got,
        input logic [DATA_W-1:0] want
    );
        $display("MISMATCH at %0t: %s, got 0x%08h, wanted 0x%08h", $realtime, what, got, want);
        fail_count++;
    endtask

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------

    task automatic add_char(input logic [CHAR_W-1:0] ch, input logic is_last);
        char_req_t req;
        req.ch      = ch;
        req.is_last = is_last;
        req.drain   = 1'b0;
        char_queue.push_back(req);
        stim_items++;
    endtask

    task automatic queue_drain();
        char_req_t req;
        req.ch      = CH_SPACE;
        req.is_last = 1'b0;
        req.drain   = 1'b1;
        char_queue.push_back(req);
    endtask

    // A valid expression with the given number of digit operands and random
    // content. With digits_first set, every digit is pushed before the first
    // operator, which drives the stack as deep as the operand count allows.
    task automatic add_wellformed(input int operands, input bit digits_first);
        int                left;
        int                height;
        bit                trail_space;
        logic [CHAR_W-1:0] ch;
        left        = operands;
        height      = 0;
        trail_space = ($urandom_range(0, 7) == 0);
        while (left > 0 || height > 1)
        begin
            if (left > 0 && (height < 2 || digits_first || $urandom_range(0, 1) == 0))
            begin
                ch = CH_ZERO + CHAR_W'($urandom_range(0, 9));
                left--;
                height++;
            end
            else
            begin
                ch = OPERATORS[$urandom_range(0, 3)];
                height--;
            end
            if ($urandom_range(0, 4) == 0)
                add_char(CH_SPACE, 1'b0);
            add_char(ch, left == 0 && height == 1 && !trail_space);
        end
        if (trail_space)
            add_char(CH_SPACE, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Sender: bursts of requests separated by random gaps. A drain entry
    // keeps the sender idle until no result is outstanding.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : sender
        char_req_t         nxt;
        logic              valid_n;
        logic [CHAR_W-1:0] data_n;
        logic              last_n;
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tlast    <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            valid_n = s_tvalid;
            data_n  = s_tdata;
            last_n  = s_tlast;
            // A request still waiting for s_tready is held exactly as it is.
            if (!s_tvalid || s_tready)
            begin
                valid_n = 1'b0;
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (char_queue.size() > 0)
                begin
                    if (char_queue[0].drain)
                    begin
                        // Only trust the outstanding count once the line is
                        // quiet, so the last request is in it.
                        if (!s_tvalid && outstanding == 0)
                            void'(char_queue.pop_front());
                    end
                    else
                    begin
                        nxt     = char_queue.pop_front();
                        valid_n = 1'b1;
                        data_n  = nxt.ch;
                        last_n  = nxt.is_last;
                        if (burst_left > 0)
                        begin
                            burst_left--;
                        end
                        else
                        begin
                            burst_left = $urandom_range(0, 24);
                            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                        end
                    end
                end
            end
            s_tvalid <= valid_n;
            s_tdata  <= data_n;
            s_tlast  <= last_n;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: changes stall pattern as rx_cycle runs, and in a
    // window of each longer period refuses results for a long stretch, so
    // the result register stays full and a final character is held off.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : receiver
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_cycle = 0;
            rx_mode  = RX_OPEN;
        end
        else
        begin
            rx_cycle++;
            if (rx_cycle % 64 == 0)
                rx_mode = rx_mode_t'($urandom_range(0, 2));
            if (rx_cycle % 4096 >= 400 && rx_cycle % 4096 < 700)
                m_tready <= 1'b0;
            else
            begin
                case (rx_mode)
                    RX_OPEN:   m_tready <= 1'b1;
                    RX_RANDOM: m_tready <= ($urandom_range(0, 1) == 1);
                    default:   m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on every accepted request and checks every accepted
    // result against the oldest prediction, field by field.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : monitor
        eval_result_t want;
        if (!rst_n)
        begin
            stack_fill = 0;
            dz_sticky  = 1'b0;
            pending_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                evaluate_char(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch("result with none expected", m_tdata, '0);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_tdata !== want.value)
                        report_mismatch("result_value", m_tdata, want.value);
                    if (m_tuser !== want.div_zero)
                        report_mismatch("divide_by_zero", {31'd0, m_tuser},
                                        {31'd0, want.div_zero});
                end
            end
            outstanding <= pending_results.size();
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: build the stimulus, release reset, wait for the last
    // result and give the verdict.
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        int pick;
        int len;
        int expr_no;
        int next_drain;

        // The most negative value divided by minus one: 2 * 8^10 is 2^31,
        // which reads as the most negative word, then 0 - 1 gives minus one.
        add_char(CH_ZERO + 8'd2, 1'b0);
        for (int i = 0; i < 10; i++)
        begin
            add_char(CH_ZERO + 8'd8, 1'b0);
            add_char(CH_STAR, 1'b0);
        end
        add_char(CH_ZERO, 1'b0);
        add_char(CH_ZERO + 8'd1, 1'b0);
        add_char(CH_MINUS, 1'b0);
        add_char(CH_SLASH, 1'b1);
        // Division by zero, then an addition that pops an empty stack.
        add_char(CH_ZERO + 8'd9, 1'b0);
        add_char(CH_ZERO, 1'b0);
        add_char(CH_SLASH, 1'b0);
        add_char(CH_PLUS, 1'b1);
        // An empty expression: only a space, marked final.
        add_char(CH_SPACE, 1'b1);
        // Unknown characters at both extremes of the byte.
        add_char(8'h00, 1'b0);
        add_char(8'hFF, 1'b1);
        queue_drain();

        // Random part: mostly valid expressions, one deep enough to overflow
        // the stack, some broken sequences and some raw noise.
        expr_no    = 0;
        next_drain = stim_items + DRAIN_EVERY;
        while (stim_items < ITEM_TARGET)
        begin
            expr_no++;
            pick = $urandom_range(0, 99);
            if (expr_no == 5)
            begin
                add_wellformed(STACK_WORDS + $urandom_range(1, 6), 1'b1);
            end
            else if (pick < 65)
            begin
                add_wellformed($urandom_range(1, 8), 1'b0);
            end
            else if (pick < 75)
            begin
                add_wellformed($urandom_range(9, 30), 1'($urandom_range(0, 1)));
            end
            else if (pick < 88)
            begin
                len = $urandom_range(1, 10);
                for (int i = 0; i < len; i++)
                begin
                    case ($urandom_range(0, 3))
                        0:       add_char(CH_ZERO + CHAR_W'($urandom_range(0, 9)), i == len - 1);
                        1:       add_char(OPERATORS[$urandom_range(0, 3)], i == len - 1);
                        2:       add_char(CH_SPACE, i == len - 1);
                        default: add_char(CHAR_W'($urandom_range(0, 255)), i == len - 1);
                    endcase
                end
            end
            else
            begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    add_char(CHAR_W'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
            end
            if (stim_items >= next_drain)
            begin
                queue_drain();
                next_drain += DRAIN_EVERY;
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Sample on the falling edge, when every process of the rising edge
        // has settled.
        while (char_queue.size() != 0 || s_tvalid || pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", DATA_W'(pending_results.size()), '0);

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog: a run that hangs ends here.
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("TB_ERROR");
        $finish;
    end

endmodule
